/* rtl/core/rmp_pkg.sv */
// ----------------------------------------------------------------------------
// rmp_pkg - shared types and constants of the requantized max pool
// Holds the register indexes, the register bank type, the queue entry type and
// the fixed limits that the front end and the back end use.
// ----------------------------------------------------------------------------
package rmp_pkg;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_ROWS       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_COLS       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_ROWS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_COLS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REQUANT_SCALE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REQUANT_SHIFT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_COUNT     = 3'd6;

   // Row and map limits, and the widths used to compare against them.
   localparam int MAX_ROWS  = 1024;
   localparam int MAX_MAPS  = 256;
   localparam int ROW_CMP_W = 12;
   localparam int MAP_CMP_W = 10;

   // Depth of the queue between front end and back end.
   localparam int QUEUE_DEPTH = 4;

   // Output clamp bounds of int8.
   localparam logic signed [31:0] Q_MAX = 32'sd127;
   localparam logic signed [31:0] Q_MIN = -32'sd128;
   localparam logic signed [32:0] ZERO_POINT = 33'sd128;

   typedef struct packed {
      logic        [10:0] in_rows;
      logic        [6:0]  in_cols;
      logic        [3:0]  pool_rows;
      logic        [3:0]  pool_cols;
      logic signed [15:0] requant_scale;
      logic        [4:0]  requant_shift;
      logic        [8:0]  map_count;
   } rmp_cfg_type;

   // One classified pixel on its way from the front end to the back end.
   typedef struct packed {
      logic signed [7:0] pixel;
      logic signed [7:0] map_weight;
      logic              first;   // opens a window: overwrite the column maximum
      logic              emit;    // closes a window: send the maximum out
      logic              done;    // last result of the last map of the job
   } rmp_item_type;

endpackage

/* rtl/core/requantized_max_pool_int8.sv */
// ----------------------------------------------------------------------------
// requantized_max_pool_int8 - requantized int8 max pooling over feature maps
// Requantizes each pixel with its map's weight, keeps the running maximum of
// every pool window in a per-column store and sends out the clamped maximum
// when a window closes.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                 | Contents (lowest bit first)
//   --------+-----------------------+------------------------------------------
//   input   | req_tvalid/tready     | tdata: pixel [7:0], map_weight [15:8]
//   result  | rsp_tvalid/tready     | tdata: pooled [7:0]; tlast: job_done
//   config  | csr_we/index/wdata    | register index 0..6, data in low bits
//
// Each item inside a whole window goes through the four steps of the back-end
// sequencer (operand multiply, scale multiply, shift, maximum update), which
// takes a new item only once it is through with the last; a four-entry queue
// lets the input side run ahead by up to four items, and pixels outside whole
// windows never enter it and are taken at one a cycle while it has room.
// A result is loaded into the output register once the item that closes its
// window has passed through the queue and the sequencer.
// Reset is synchronous and active high; it restores the register reset values
// and clears the position counters. The column store is not cleared: every
// window's first item overwrites its entry without using the old value.
// A stalled result holds in the output register and stops the sequencer at
// the next item that closes a window; the input side keeps accepting until the
// queue is full.

module requantized_max_pool_int8 #(
   parameter int MAX_COLS = 64,
   parameter int MAX_POOL = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input items.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // pixel, map_weight
   // Result items.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // pooled
   output logic                               rsp_tlast,   // job_done
   // Configuration writes.
   input  logic                               csr_we,
   input  logic [rmp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rmp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   rmp_pkg::rmp_cfg_type  cfg_ff, cfg_in;
   rmp_pkg::rmp_item_type push_item, head_item;
   logic [IDX_W-1:0]      push_idx, head_idx;
   logic                  push, queue_full, pop, head_valid;
   logic signed [7:0]     pooled;

   // Register bank. Writes beyond the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rmp_pkg::CSR_IN_ROWS:       cfg_in.in_rows       = csr_wdata[10:0];
            rmp_pkg::CSR_IN_COLS:       cfg_in.in_cols       = csr_wdata[6:0];
            rmp_pkg::CSR_POOL_ROWS:     cfg_in.pool_rows     = csr_wdata[3:0];
            rmp_pkg::CSR_POOL_COLS:     cfg_in.pool_cols     = csr_wdata[3:0];
            rmp_pkg::CSR_REQUANT_SCALE: cfg_in.requant_scale = csr_wdata[15:0];
            rmp_pkg::CSR_REQUANT_SHIFT: cfg_in.requant_shift = csr_wdata[4:0];
            rmp_pkg::CSR_MAP_COUNT:     cfg_in.map_count     = csr_wdata[8:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_rows       <= 11'd28;
         cfg_ff.in_cols       <= 7'd28;
         cfg_ff.pool_rows     <= 4'd2;
         cfg_ff.pool_cols     <= 4'd2;
         cfg_ff.requant_scale <= 16'sd193;
         cfg_ff.requant_shift <= 5'd15;
         cfg_ff.map_count     <= 9'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end tracks where each pixel falls and queues only those
   // inside whole windows, tagged with what the back end must do.
   rmp_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_POOL (MAX_POOL)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pixel   (req_tdata[7:0]),
      .in_weight  (req_tdata[15:8]),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item),
      .push_idx   (push_idx)
   );

   rmp_queue #(
      .DEPTH (rmp_pkg::QUEUE_DEPTH),
      .IDX_W (IDX_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_idx   (push_idx),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_idx   (head_idx)
   );

   // The back end works through one queued item at a time and owns the
   // column store and the output register.
   rmp_back #(
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_idx   (head_idx),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_pooled (pooled),
      .rsp_done   (rsp_tlast)
   );

   assign rsp_tdata = pooled;

endmodule

/* rtl/core/rmp_queue.sv */
// ----------------------------------------------------------------------------
// rmp_queue - short queue between front end and back end
// A small register queue carrying classified pixels and their column index.
// ----------------------------------------------------------------------------
module rmp_queue #(
   parameter int DEPTH = 4,
   parameter int IDX_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rmp_pkg::rmp_item_type push_item,
   input  logic [IDX_W-1:0]      push_idx,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output rmp_pkg::rmp_item_type head_item,
   output logic [IDX_W-1:0]      head_idx
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rmp_pkg::rmp_item_type item_ff [DEPTH];
   logic [IDX_W-1:0]      idx_ff  [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = item_ff[rd_ptr_ff];
   assign head_idx   = idx_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= push_item;
         idx_ff[wr_ptr_ff]  <= push_idx;
      end
   end

endmodule

/* rtl/core/rmp_front.sv */
// ----------------------------------------------------------------------------
// rmp_front - position tracking and classification of pixels
// Follows each pixel's place in the map and its window, drops pixels outside
// whole windows and queues the rest with their window flags.
// ----------------------------------------------------------------------------
module rmp_front #(
   parameter int MAX_COLS = 64,
   parameter int MAX_POOL = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rmp_pkg::rmp_cfg_type   cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [7:0]      in_pixel,
   input  logic signed [7:0]      in_weight,
   input  logic                   queue_full,
   output logic                   push,
   output rmp_pkg::rmp_item_type  push_item,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] push_idx
);

   localparam int IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int WIN_W  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
   localparam int CCMP_W = $clog2(MAX_COLS + 2 * MAX_POOL + 128);
   localparam int PCMP_W = $clog2(MAX_POOL + 17);
   localparam int RW     = rmp_pkg::ROW_CMP_W;
   localparam int MW     = rmp_pkg::MAP_CMP_W;

   logic [9:0]       row_pos_ff, row_pos_in;
   logic [IDX_W-1:0] col_pos_ff, col_pos_in;
   logic [WIN_W-1:0] win_row_ff, win_row_in;
   logic [WIN_W-1:0] win_col_ff, win_col_in;
   logic [IDX_W-1:0] out_col_ff, out_col_in;
   logic [7:0]       map_index_ff, map_index_in;

   logic [RW-1:0]     rows_s, row_ext, pr_r;
   logic [CCMP_W-1:0] cols_s, col_ext, wc_c, pc_c;
   logic [PCMP_W-1:0] pr_s, pc_s, wr_p, wc_p;
   logic [MW-1:0]     mc_s;
   logic              accept, in_r, in_c, last_row, last_col, last_map;
   logic              col_wrap, row_wrap, wr_wrap, wc_wrap;

   // Register values saturated to their ranges; zero counts as one.
   always_comb begin
      if (cfg.in_rows == '0) begin
         rows_s = RW'(1);
      end else if (RW'(cfg.in_rows) > RW'(rmp_pkg::MAX_ROWS)) begin
         rows_s = RW'(rmp_pkg::MAX_ROWS);
      end else begin
         rows_s = RW'(cfg.in_rows);
      end
      if (cfg.in_cols == '0) begin
         cols_s = CCMP_W'(1);
      end else if (CCMP_W'(cfg.in_cols) > CCMP_W'(MAX_COLS)) begin
         cols_s = CCMP_W'(MAX_COLS);
      end else begin
         cols_s = CCMP_W'(cfg.in_cols);
      end
      if (cfg.pool_rows == '0) begin
         pr_s = PCMP_W'(1);
      end else if (PCMP_W'(cfg.pool_rows) > PCMP_W'(MAX_POOL)) begin
         pr_s = PCMP_W'(MAX_POOL);
      end else begin
         pr_s = PCMP_W'(cfg.pool_rows);
      end
      if (cfg.pool_cols == '0) begin
         pc_s = PCMP_W'(1);
      end else if (PCMP_W'(cfg.pool_cols) > PCMP_W'(MAX_POOL)) begin
         pc_s = PCMP_W'(MAX_POOL);
      end else begin
         pc_s = PCMP_W'(cfg.pool_cols);
      end
      if (cfg.map_count == '0) begin
         mc_s = MW'(1);
      end else if (MW'(cfg.map_count) > MW'(rmp_pkg::MAX_MAPS)) begin
         mc_s = MW'(rmp_pkg::MAX_MAPS);
      end else begin
         mc_s = MW'(cfg.map_count);
      end
   end

   assign accept   = in_valid && !queue_full;
   assign in_ready = !queue_full;

   assign row_ext = RW'(row_pos_ff);
   assign pr_r    = RW'(pr_s);
   assign col_ext = CCMP_W'(col_pos_ff);
   assign wc_c    = CCMP_W'(win_col_ff);
   assign pc_c    = CCMP_W'(pc_s);
   assign wr_p    = PCMP_W'(win_row_ff);
   assign wc_p    = PCMP_W'(win_col_ff);

   // A pixel lies in a whole window when the window that it belongs to ends
   // inside the map.
   assign in_r = (row_ext - RW'(win_row_ff) + pr_r) <= rows_s;
   assign in_c = (col_ext - wc_c + pc_c) <= cols_s;

   // The window just closed is the last whole one of its row or column when
   // a further window would not fit.
   assign last_row = (row_ext + RW'(1) + pr_r) > rows_s;
   assign last_col = (col_ext + CCMP_W'(1) + pc_c) > cols_s;
   assign last_map = (MW'(map_index_ff) + MW'(1)) >= mc_s;

   assign col_wrap = (col_ext + CCMP_W'(1)) >= cols_s;
   assign row_wrap = (row_ext + RW'(1)) >= rows_s;
   assign wr_wrap  = (wr_p + PCMP_W'(1)) >= pr_s;
   assign wc_wrap  = (wc_p + PCMP_W'(1)) >= pc_s;

   always_comb begin
      push                 = accept && in_r && in_c;
      push_item.pixel      = in_pixel;
      push_item.map_weight = in_weight;
      push_item.first      = (win_row_ff == '0) && (win_col_ff == '0);
      push_item.emit       = wr_wrap && wc_wrap;
      push_item.done       = last_map && last_row && last_col;
      push_idx             = out_col_ff;
   end

   always_comb begin
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      win_row_in   = win_row_ff;
      win_col_in   = win_col_ff;
      out_col_in   = out_col_ff;
      map_index_in = map_index_ff;
      if (accept) begin
         if (col_wrap) begin
            col_pos_in = '0;
            win_col_in = '0;
            out_col_in = '0;
            if (row_wrap) begin
               row_pos_in   = '0;
               win_row_in   = '0;
               map_index_in = last_map ? '0 : map_index_ff + 1'b1;
            end else begin
               row_pos_in = row_pos_ff + 1'b1;
               win_row_in = wr_wrap ? '0 : win_row_ff + 1'b1;
            end
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
            if (wc_wrap) begin
               win_col_in = '0;
               out_col_in = out_col_ff + 1'b1;
            end else begin
               win_col_in = win_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         win_row_ff   <= '0;
         win_col_ff   <= '0;
         out_col_ff   <= '0;
         map_index_ff <= '0;
      end else begin
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         win_row_ff   <= win_row_in;
         win_col_ff   <= win_col_in;
         out_col_ff   <= out_col_in;
         map_index_ff <= map_index_in;
      end
   end

endmodule

/* rtl/core/rmp_back.sv */
// ----------------------------------------------------------------------------
// rmp_back - requantization and window maximum update
// Takes queued pixels one at a time, requantizes them with an operand multiply,
// a scale multiply and a shift, updates the per-column maximum and loads
// finished results into the output register.
// ----------------------------------------------------------------------------
module rmp_back #(
   parameter int MAX_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rmp_pkg::rmp_cfg_type  cfg,
   input  logic                  head_valid,
   input  rmp_pkg::rmp_item_type head_item,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] head_idx,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [7:0]     rsp_pooled,
   output logic                  rsp_done
);

   localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MUL   = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_UPD   = 2'd3;

   logic [1:0]            state_ff, state_in;
   rmp_pkg::rmp_item_type item_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [15:0]           prod1_ff;
   logic signed [31:0]    prod2_ff;
   logic signed [31:0]    value_ff;
   logic signed [31:0]    stored_ff;
   logic signed [31:0]    col_max_mem [MAX_COLS];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]     rsp_pooled_ff;
   logic                  rsp_done_ff;

   logic [7:0]         pix_u, wt_u;
   logic signed [32:0] prod_full;
   logic signed [32:0] value_full;
   logic signed [31:0] new_max;
   logic signed [7:0]  clamped;
   logic               slot_free, load_rsp;

   // Adding the zero point of 128 to an int8 is a flip of its top bit.
   assign pix_u = {~head_item.pixel[7], head_item.pixel[6:0]};
   assign wt_u  = {~head_item.map_weight[7], head_item.map_weight[6:0]};

   assign prod_full  = 33'($signed({1'b0, prod1_ff})) * 33'(cfg.requant_scale);
   assign value_full = (prod2_ff >>> cfg.requant_shift) - rmp_pkg::ZERO_POINT;

   assign new_max = (item_ff.first || (value_ff > stored_ff)) ? value_ff : stored_ff;

   always_comb begin
      if (new_max > rmp_pkg::Q_MAX) begin
         clamped = rmp_pkg::Q_MAX[7:0];
      end else if (new_max < rmp_pkg::Q_MIN) begin
         clamped = rmp_pkg::Q_MIN[7:0];
      end else begin
         clamped = new_max[7:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == S_IDLE) && head_valid;
   assign load_rsp  = (state_ff == S_UPD) && item_ff.emit && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               state_in = S_MUL;
            end
         end
         S_MUL:   state_in = S_SHIFT;
         S_SHIFT: state_in = S_UPD;
         S_UPD: begin
            if (!item_ff.emit || slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff   <= head_item;
         idx_ff    <= head_idx;
         prod1_ff  <= 16'(pix_u) * 16'(wt_u);
         stored_ff <= col_max_mem[head_idx];
      end
      if (state_ff == S_MUL) begin
         prod2_ff <= prod_full[31:0];
      end
      if (state_ff == S_SHIFT) begin
         value_ff <= value_full[31:0];
      end
      if (state_ff == S_UPD) begin
         col_max_mem[idx_ff] <= new_max;
      end
      if (load_rsp) begin
         rsp_pooled_ff <= clamped;
         rsp_done_ff   <= item_ff.done;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pooled = rsp_pooled_ff;
   assign rsp_done   = rsp_done_ff;

endmodule

/* rtl/core/rmp_checker.sv */
// ----------------------------------------------------------------------------
// rmp_checker - port checks of the requantized max pool
// Watches the top-level ports for result stalls, reset behaviour and the
// shortest possible latency of the back end.
// ----------------------------------------------------------------------------
module rmp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled result item stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   // A stalled result item keeps its contents.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item offered right after reset");

   // After reset, no result can be offered before an item has had time to pass
   // through the queue and every sequencer state.
   a_min_latency: assert property (@(posedge clock)
      $past(reset) || $past(reset, 2) || $past(reset, 3) |-> !rsp_tvalid)
      else $error("result item appeared faster than the back end allows");

endmodule

bind requantized_max_pool_int8 rmp_checker u_rmp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
